// File: rtl/swhf_pkg.sv
// shared constants and saturation helpers for the shallow water hll flux block
package swhf_pkg;

    // fixed point fraction bits
    localparam int FRAC_BITS = 16;

    // square root: radicand is a 31-bit c2 shifted up by the fraction bits
    localparam int SQ_IN_W   = 31 + FRAC_BITS;
    localparam int SQ_STAGES = (SQ_IN_W + 1) / 2;

    // divider: 32-bit result plus one guard bit
    localparam int DIV_QBITS = 33;
    localparam int DIV_LAT   = DIV_QBITS + 1;

    localparam logic signed [65:0] MAX32_W = 66'sd2147483647;
    localparam logic signed [65:0] MIN32_W = -66'sd2147483648;
    localparam logic signed [65:0] MAX64_W = 66'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] MIN64_W = 66'h3_8000_0000_0000_0000;

    // clamp to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > MAX32_W) begin
            return 32'sh7FFF_FFFF;
        end else if (x < MIN32_W) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // clamp to the 64-bit signed range
    function automatic logic signed [63:0] sat64(input logic signed [65:0] x);
        if (x > MAX64_W) begin
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        end else if (x < MIN64_W) begin
            return 64'sh8000_0000_0000_0000;
        end
        return x[63:0];
    endfunction

    // rescale a fixed point product: floor shift then clamp
    function automatic logic signed [31:0] qs(input logic signed [65:0] p);
        return sat32(p >>> FRAC_BITS);
    endfunction

endpackage

// File: rtl/swhf_in_if.sv
// edge word channel: left and right cell states and the edge frame
interface swhf_in_if;
    logic               valid;
    logic               ready;
    logic        [30:0] depth_left;
    logic signed [31:0] vel_x_left;
    logic signed [31:0] vel_y_left;
    logic        [30:0] depth_right;
    logic signed [31:0] vel_x_right;
    logic signed [31:0] vel_y_right;
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic signed [17:0] tangent_x;
    logic signed [17:0] tangent_y;
    logic signed [31:0] source_left;
    logic signed [31:0] source_right;

    modport source (
        output valid, depth_left, vel_x_left, vel_y_left, depth_right, vel_x_right,
               vel_y_right, normal_x, normal_y, tangent_x, tangent_y, source_left,
               source_right,
        input  ready
    );
    modport sink (
        input  valid, depth_left, vel_x_left, vel_y_left, depth_right, vel_x_right,
               vel_y_right, normal_x, normal_y, tangent_x, tangent_y, source_left,
               source_right,
        output ready
    );
endinterface

// File: rtl/swhf_out_if.sv
// flux word channel: mass, normal and tangential momentum flux
interface swhf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] flux_mass;
    logic signed [31:0] flux_normal;
    logic signed [31:0] flux_tangent;

    modport source (
        output valid, flux_mass, flux_normal, flux_tangent,
        input  ready
    );
    modport sink (
        input  valid, flux_mass, flux_normal, flux_tangent,
        output ready
    );
endinterface

// File: rtl/swhf_div.sv
// pipelined restoring divider, one quotient bit per stage, saturated signed result
module swhf_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic        [63:0] i_mag,
    input  logic               i_neg,
    input  logic        [32:0] i_div,
    output logic signed [31:0] o_quot
);
    localparam int QB = swhf_pkg::DIV_QBITS;
    localparam int MW = 64;
    localparam int DW = 33;
    localparam logic [QB-1:0] Q_MIN_MAG = QB'(64'h8000_0000);
    localparam logic [QB-1:0] Q_MAX_MAG = QB'(64'h7FFF_FFFF);

    logic [DW-1:0] r_rem  [QB];
    logic [MW-1:0] r_mag  [QB];
    logic [QB-1:0] r_quot [QB];
    logic [DW-1:0] r_div  [QB];
    logic          r_neg  [QB];
    logic          r_ovf  [QB];
    logic signed [31:0] r_quot_out;

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DW-1:0] w_rem_in, w_div_in, n_rem;
        logic [MW-1:0] w_mag_in;
        logic [QB-1:0] w_quot_in, n_quot;
        logic          w_neg_in, w_ovf_in;
        logic [DW:0]   w_trial;

        if (k == 0) begin : g_first
            // high dividend bits seed the remainder; a quotient past the guard bit overflows
            assign w_rem_in  = DW'(i_mag[MW-1:QB]);
            assign w_mag_in  = i_mag;
            assign w_quot_in = '0;
            assign w_div_in  = i_div;
            assign w_neg_in  = i_neg;
            assign w_ovf_in  = DW'(i_mag[MW-1:QB]) >= i_div;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_mag_in  = r_mag[k-1];
            assign w_quot_in = r_quot[k-1];
            assign w_div_in  = r_div[k-1];
            assign w_neg_in  = r_neg[k-1];
            assign w_ovf_in  = r_ovf[k-1];
        end

        // shift in one dividend bit, subtract when it fits
        always_comb begin
            w_trial = {w_rem_in, w_mag_in[QB-1-k]};
            if (w_trial >= {1'b0, w_div_in}) begin
                n_rem  = DW'(w_trial - {1'b0, w_div_in});
                n_quot = {w_quot_in[QB-2:0], 1'b1};
            end else begin
                n_rem  = DW'(w_trial);
                n_quot = {w_quot_in[QB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_mag[k]  <= w_mag_in;
                r_quot[k] <= n_quot;
                r_div[k]  <= w_div_in;
                r_neg[k]  <= w_neg_in;
                r_ovf[k]  <= w_ovf_in;
            end
        end
    end

    // apply sign and clamp to 32 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QB-1]) begin
                if (r_ovf[QB-1] || (r_quot[QB-1] > Q_MIN_MAG)) begin
                    r_quot_out <= 32'sh8000_0000;
                end else begin
                    r_quot_out <= $signed(32'(QB'(0) - r_quot[QB-1]));
                end
            end else begin
                if (r_ovf[QB-1] || (r_quot[QB-1] > Q_MAX_MAG)) begin
                    r_quot_out <= 32'sh7FFF_FFFF;
                end else begin
                    r_quot_out <= $signed(r_quot[QB-1][31:0]);
                end
            end
        end
    end

    assign o_quot = r_quot_out;

endmodule

// File: rtl/shallow_water_hll_flux.sv
// top level: hll flux across one mesh edge for the shallow water equations
//
//  channel   dir  handshake       word
//  i_edge    in   valid / ready   depths, velocities, sources, normal, tangent
//  o_flux    out  valid / ready   flux_mass, flux_normal, flux_tangent
//  i_cfg_*   in   write enable    gravity
//
// one edge word per cycle unless the output word is not taken; a word passes
// through 3 projection stages, 24 square root stages (one root bit each), 10 flux
// and blend stages, 34 divider stages (33 quotient bit stages and a sign stage)
// and the output register
// reset clears all valid bits and sets gravity to its default
// the whole pipeline holds while a result waits in the output register
module shallow_water_hll_flux (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    swhf_in_if.sink     i_edge,
    swhf_out_if.source  o_flux
);
    localparam int F     = swhf_pkg::FRAC_BITS;
    localparam int SQN   = swhf_pkg::SQ_STAGES;
    localparam int SQV   = 2 * SQN;
    localparam int PW    = 62 - F - 1;
    localparam int DLAT  = swhf_pkg::DIV_LAT;

    typedef struct packed {
        logic        [30:0] hl;
        logic        [30:0] hr;
        logic signed [31:0] unl;
        logic signed [31:0] utl;
        logic signed [31:0] unr;
        logic signed [31:0] utr;
        logic signed [31:0] u;
        logic signed [32:0] ds;
    } t_side;

    typedef struct packed {
        logic               sel_left;
        logic               sel_right;
        logic signed [31:0] res0;
        logic signed [31:0] res1;
        logic signed [31:0] res2;
        logic signed [32:0] ds;
    } t_tail;

    logic w_en;
    logic r_out_valid;
    logic [30:0] r_gravity;

    // stall everything while the output word is not taken
    assign w_en         = !r_out_valid || o_flux.ready;
    assign i_edge.ready = w_en;

    // gravity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= 31'd642908;
        end else if (i_cfg_we) begin
            r_gravity <= i_cfg_wdata;
        end
    end

    // stage 1: projection products, depth sum and source difference
    logic               r_s1_valid;
    logic signed [49:0] r_s1_pnl_x, r_s1_pnl_y, r_s1_ptl_x, r_s1_ptl_y;
    logic signed [49:0] r_s1_pnr_x, r_s1_pnr_y, r_s1_ptr_x, r_s1_ptr_y;
    logic        [31:0] r_s1_hs;
    logic        [30:0] r_s1_hl, r_s1_hr;
    logic signed [32:0] r_s1_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_edge.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pnl_x <= i_edge.vel_x_left * i_edge.normal_x;
            r_s1_pnl_y <= i_edge.vel_y_left * i_edge.normal_y;
            r_s1_ptl_x <= i_edge.vel_x_left * i_edge.tangent_x;
            r_s1_ptl_y <= i_edge.vel_y_left * i_edge.tangent_y;
            r_s1_pnr_x <= i_edge.vel_x_right * i_edge.normal_x;
            r_s1_pnr_y <= i_edge.vel_y_right * i_edge.normal_y;
            r_s1_ptr_x <= i_edge.vel_x_right * i_edge.tangent_x;
            r_s1_ptr_y <= i_edge.vel_y_right * i_edge.tangent_y;
            r_s1_hs    <= {1'b0, i_edge.depth_left} + {1'b0, i_edge.depth_right};
            r_s1_hl    <= i_edge.depth_left;
            r_s1_hr    <= i_edge.depth_right;
            r_s1_ds    <= 33'(i_edge.source_right) - 33'(i_edge.source_left);
        end
    end

    // stage 2: normal and tangential speeds, g times depth sum
    logic               r_s2_valid;
    logic signed [31:0] r_s2_unl, r_s2_utl, r_s2_unr, r_s2_utr;
    logic        [62:0] r_s2_ghs;
    logic        [30:0] r_s2_hl, r_s2_hr;
    logic signed [32:0] r_s2_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_unl <= swhf_pkg::qs(66'(r_s1_pnl_x) + 66'(r_s1_pnl_y));
            r_s2_utl <= swhf_pkg::qs(66'(r_s1_ptl_x) + 66'(r_s1_ptl_y));
            r_s2_unr <= swhf_pkg::qs(66'(r_s1_pnr_x) + 66'(r_s1_pnr_y));
            r_s2_utr <= swhf_pkg::qs(66'(r_s1_ptr_x) + 66'(r_s1_ptr_y));
            r_s2_ghs <= r_gravity * r_s1_hs;
            r_s2_hl  <= r_s1_hl;
            r_s2_hr  <= r_s1_hr;
            r_s2_ds  <= r_s1_ds;
        end
    end

    // stage 3: clamped c squared and mean normal speed
    logic        r_s3_valid;
    logic [30:0] r_s3_c2;
    t_side       r_s3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if ((r_s2_ghs >> (F + 1)) > 63'h7FFF_FFFF) begin
                r_s3_c2 <= 31'h7FFF_FFFF;
            end else begin
                r_s3_c2 <= 31'(r_s2_ghs >> (F + 1));
            end
            r_s3_side.hl  <= r_s2_hl;
            r_s3_side.hr  <= r_s2_hr;
            r_s3_side.unl <= r_s2_unl;
            r_s3_side.utl <= r_s2_utl;
            r_s3_side.unr <= r_s2_unr;
            r_s3_side.utr <= r_s2_utr;
            r_s3_side.u   <= 32'((33'(r_s2_unl) + 33'(r_s2_unr)) >>> 1);
            r_s3_side.ds  <= r_s2_ds;
        end
    end

    // square root stages, one result bit each
    logic           r_sq_valid [SQN];
    t_side          r_sq_side  [SQN];
    logic [SQV-1:0] r_sq_v     [SQN];
    logic [SQV-1:0] r_sq_r     [SQN];

    for (genvar k = 0; k < SQN; k++) begin : g_sq
        localparam logic [SQV-1:0] SQ_BIT = SQV'(1) << (2 * (SQN - 1 - k));
        logic           w_valid_in;
        t_side          w_side_in;
        logic [SQV-1:0] w_v_in, w_r_in, w_trial, n_v, n_r;

        if (k == 0) begin : g_first
            assign w_valid_in = r_s3_valid;
            assign w_side_in  = r_s3_side;
            assign w_v_in     = SQV'({r_s3_c2, {F{1'b0}}});
            assign w_r_in     = '0;
        end else begin : g_next
            assign w_valid_in = r_sq_valid[k-1];
            assign w_side_in  = r_sq_side[k-1];
            assign w_v_in     = r_sq_v[k-1];
            assign w_r_in     = r_sq_r[k-1];
        end

        always_comb begin
            w_trial = w_r_in + SQ_BIT;
            if (w_v_in >= w_trial) begin
                n_v = w_v_in - w_trial;
                n_r = (w_r_in >> 1) + SQ_BIT;
            end else begin
                n_v = w_v_in;
                n_r = w_r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k] <= 1'b0;
            end else if (w_en) begin
                r_sq_valid[k] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_side[k] <= w_side_in;
                r_sq_v[k]    <= n_v;
                r_sq_r[k]    <= n_r;
            end
        end
    end

    // p1: wave speeds and first flux products
    t_side              w_sd;
    logic     [SQN-1:0] w_c;
    logic        [30:0] w_p1_h  [2];
    logic signed [31:0] w_p1_un [2];
    logic signed [31:0] w_p1_ut [2];

    assign w_sd = r_sq_side[SQN-1];
    assign w_c  = r_sq_r[SQN-1][SQN-1:0];

    always_comb begin
        w_p1_h[0]  = w_sd.hl;
        w_p1_h[1]  = w_sd.hr;
        w_p1_un[0] = w_sd.unl;
        w_p1_un[1] = w_sd.unr;
        w_p1_ut[0] = w_sd.utl;
        w_p1_ut[1] = w_sd.utr;
    end

    logic               r_p1_valid;
    logic        [61:0] r_p1_gh   [2];
    logic signed [63:0] r_p1_hun  [2];
    logic signed [63:0] r_p1_hut  [2];
    logic signed [63:0] r_p1_unun [2];
    logic signed [63:0] r_p1_unut [2];
    logic        [30:0] r_p1_h    [2];
    logic signed [31:0] r_p1_l1, r_p1_l2;
    logic signed [32:0] r_p1_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= r_sq_valid[SQN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < 2; s++) begin
                r_p1_gh[s]   <= r_gravity * w_p1_h[s];
                r_p1_hun[s]  <= $signed({1'b0, w_p1_h[s]}) * w_p1_un[s];
                r_p1_hut[s]  <= $signed({1'b0, w_p1_h[s]}) * w_p1_ut[s];
                r_p1_unun[s] <= w_p1_un[s] * w_p1_un[s];
                r_p1_unut[s] <= w_p1_un[s] * w_p1_ut[s];
                r_p1_h[s]    <= w_p1_h[s];
            end
            r_p1_l1 <= swhf_pkg::sat32(66'(w_sd.u) - 66'($signed({1'b0, w_c})));
            r_p1_l2 <= swhf_pkg::sat32(66'(w_sd.u) + 66'($signed({1'b0, w_c})));
            r_p1_ds <= w_sd.ds;
        end
    end

    // p2: rescale products, pick the branch
    logic               r_p2_valid;
    logic        [30:0] r_p2_gh [2];
    logic signed [31:0] r_p2_f0 [2];
    logic signed [31:0] r_p2_u2 [2];
    logic signed [31:0] r_p2_uu [2];
    logic signed [31:0] r_p2_w  [2];
    logic        [30:0] r_p2_h  [2];
    logic signed [31:0] r_p2_l1, r_p2_l2;
    logic               r_p2_sel_left, r_p2_sel_right;
    logic signed [32:0] r_p2_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (w_en) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < 2; s++) begin
                if ((r_p1_gh[s] >> F) > 62'h7FFF_FFFF) begin
                    r_p2_gh[s] <= 31'h7FFF_FFFF;
                end else begin
                    r_p2_gh[s] <= 31'(r_p1_gh[s] >> F);
                end
                r_p2_f0[s] <= swhf_pkg::qs(66'(r_p1_hun[s]));
                r_p2_u2[s] <= swhf_pkg::qs(66'(r_p1_hut[s]));
                r_p2_uu[s] <= swhf_pkg::qs(66'(r_p1_unun[s]));
                r_p2_w[s]  <= swhf_pkg::qs(66'(r_p1_unut[s]));
                r_p2_h[s]  <= r_p1_h[s];
            end
            r_p2_l1        <= r_p1_l1;
            r_p2_l2        <= r_p1_l2;
            r_p2_sel_left  <= !r_p1_l1[31];
            r_p2_sel_right <= r_p1_l2[31];
            r_p2_ds        <= r_p1_ds;
        end
    end

    // p3: second flux products, conserved differences
    logic               r_p3_valid;
    logic        [61:0] r_p3_ghh [2];
    logic signed [63:0] r_p3_uuh [2];
    logic signed [63:0] r_p3_wh  [2];
    logic signed [31:0] r_p3_f0  [2];
    logic signed [31:0] r_p3_du  [3];
    logic signed [31:0] r_p3_l1, r_p3_l2;
    logic               r_p3_sel_left, r_p3_sel_right;
    logic signed [32:0] r_p3_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (w_en) begin
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < 2; s++) begin
                r_p3_ghh[s] <= r_p2_gh[s] * r_p2_h[s];
                r_p3_uuh[s] <= r_p2_uu[s] * $signed({1'b0, r_p2_h[s]});
                r_p3_wh[s]  <= r_p2_w[s] * $signed({1'b0, r_p2_h[s]});
                r_p3_f0[s]  <= r_p2_f0[s];
            end
            r_p3_du[0] <= $signed({1'b0, r_p2_h[1]}) - $signed({1'b0, r_p2_h[0]});
            r_p3_du[1] <= swhf_pkg::sat32(66'(r_p2_f0[1]) - 66'(r_p2_f0[0]));
            r_p3_du[2] <= swhf_pkg::sat32(66'(r_p2_u2[1]) - 66'(r_p2_u2[0]));
            r_p3_l1        <= r_p2_l1;
            r_p3_l2        <= r_p2_l2;
            r_p3_sel_left  <= r_p2_sel_left;
            r_p3_sel_right <= r_p2_sel_right;
            r_p3_ds        <= r_p2_ds;
        end
    end

    // p4: pressure term and rescaled momentum parts
    logic               r_p4_valid;
    logic      [PW-1:0] r_p4_p  [2];
    logic signed [31:0] r_p4_m1 [2];
    logic signed [31:0] r_p4_f2 [2];
    logic signed [31:0] r_p4_f0 [2];
    logic signed [31:0] r_p4_du [3];
    logic signed [31:0] r_p4_l1, r_p4_l2;
    logic               r_p4_sel_left, r_p4_sel_right;
    logic signed [32:0] r_p4_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_valid <= 1'b0;
        end else if (w_en) begin
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < 2; s++) begin
                r_p4_p[s]  <= PW'(r_p3_ghh[s] >> (F + 1));
                r_p4_m1[s] <= swhf_pkg::qs(66'(r_p3_uuh[s]));
                r_p4_f2[s] <= swhf_pkg::qs(66'(r_p3_wh[s]));
                r_p4_f0[s] <= r_p3_f0[s];
            end
            r_p4_du        <= r_p3_du;
            r_p4_l1        <= r_p3_l1;
            r_p4_l2        <= r_p3_l2;
            r_p4_sel_left  <= r_p3_sel_left;
            r_p4_sel_right <= r_p3_sel_right;
            r_p4_ds        <= r_p3_ds;
        end
    end

    // p5: physical fluxes complete
    logic               r_p5_valid;
    logic signed [31:0] r_p5_f  [2][3];
    logic signed [31:0] r_p5_du [3];
    logic signed [31:0] r_p5_l1, r_p5_l2;
    logic               r_p5_sel_left, r_p5_sel_right;
    logic signed [32:0] r_p5_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_valid <= 1'b0;
        end else if (w_en) begin
            r_p5_valid <= r_p4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < 2; s++) begin
                r_p5_f[s][0] <= r_p4_f0[s];
                r_p5_f[s][1] <= swhf_pkg::sat32(66'($signed({1'b0, r_p4_p[s]}))
                                                + 66'(r_p4_m1[s]));
                r_p5_f[s][2] <= r_p4_f2[s];
            end
            r_p5_du        <= r_p4_du;
            r_p5_l1        <= r_p4_l1;
            r_p5_l2        <= r_p4_l2;
            r_p5_sel_left  <= r_p4_sel_left;
            r_p5_sel_right <= r_p4_sel_right;
            r_p5_ds        <= r_p4_ds;
        end
    end

    // p6: blend products, one-sided result
    logic signed [32:0] w_nl1;
    assign w_nl1 = 33'sd0 - 33'(r_p5_l1);

    logic               r_p6_valid;
    logic signed [63:0] r_p6_ll;
    logic signed [63:0] r_p6_a   [3];
    logic signed [64:0] r_p6_b   [3];
    logic signed [31:0] r_p6_res [3];
    logic signed [31:0] r_p6_du  [3];
    logic signed [31:0] r_p6_l1, r_p6_l2;
    logic               r_p6_sel_left, r_p6_sel_right;
    logic signed [32:0] r_p6_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p6_valid <= 1'b0;
        end else if (w_en) begin
            r_p6_valid <= r_p5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p6_ll <= r_p5_l1 * r_p5_l2;
            for (int j = 0; j < 3; j++) begin
                r_p6_a[j]   <= r_p5_l2 * r_p5_f[0][j];
                r_p6_b[j]   <= w_nl1 * r_p5_f[1][j];
                r_p6_res[j] <= r_p5_sel_left ? r_p5_f[0][j] : r_p5_f[1][j];
            end
            r_p6_du        <= r_p5_du;
            r_p6_l1        <= r_p5_l1;
            r_p6_l2        <= r_p5_l2;
            r_p6_sel_left  <= r_p5_sel_left;
            r_p6_sel_right <= r_p5_sel_right;
            r_p6_ds        <= r_p5_ds;
        end
    end

    // p7: wave speed product, first partial sum, divisor
    logic               r_p7_valid;
    logic signed [31:0] r_p7_q;
    logic signed [63:0] r_p7_s   [3];
    logic        [32:0] r_p7_d;
    logic signed [31:0] r_p7_res [3];
    logic signed [31:0] r_p7_du  [3];
    logic               r_p7_sel_left, r_p7_sel_right;
    logic signed [32:0] r_p7_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p7_valid <= 1'b0;
        end else if (w_en) begin
            r_p7_valid <= r_p6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p7_q <= swhf_pkg::qs(66'(r_p6_ll));
            for (int j = 0; j < 3; j++) begin
                r_p7_s[j] <= swhf_pkg::sat64(66'(r_p6_a[j]) + 66'(r_p6_b[j]));
            end
            r_p7_d         <= 33'(r_p6_l2) - 33'(r_p6_l1);
            r_p7_res       <= r_p6_res;
            r_p7_du        <= r_p6_du;
            r_p7_sel_left  <= r_p6_sel_left;
            r_p7_sel_right <= r_p6_sel_right;
            r_p7_ds        <= r_p6_ds;
        end
    end

    // p8: wave speed product times conserved difference
    logic               r_p8_valid;
    logic signed [63:0] r_p8_qdu [3];
    logic signed [63:0] r_p8_s   [3];
    logic        [32:0] r_p8_d;
    logic signed [31:0] r_p8_res [3];
    logic               r_p8_sel_left, r_p8_sel_right;
    logic signed [32:0] r_p8_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p8_valid <= 1'b0;
        end else if (w_en) begin
            r_p8_valid <= r_p7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_p8_qdu[j] <= r_p7_q * r_p7_du[j];
            end
            r_p8_s         <= r_p7_s;
            r_p8_d         <= r_p7_d;
            r_p8_res       <= r_p7_res;
            r_p8_sel_left  <= r_p7_sel_left;
            r_p8_sel_right <= r_p7_sel_right;
            r_p8_ds        <= r_p7_ds;
        end
    end

    // p9: blend numerators
    logic               r_p9_valid;
    logic signed [63:0] r_p9_n   [3];
    logic        [32:0] r_p9_d;
    logic signed [31:0] r_p9_res [3];
    logic               r_p9_sel_left, r_p9_sel_right;
    logic signed [32:0] r_p9_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p9_valid <= 1'b0;
        end else if (w_en) begin
            r_p9_valid <= r_p8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_p9_n[j] <= swhf_pkg::sat64(66'(r_p8_s[j]) + 66'(r_p8_qdu[j]));
            end
            r_p9_d         <= r_p8_d;
            r_p9_res       <= r_p8_res;
            r_p9_sel_left  <= r_p8_sel_left;
            r_p9_sel_right <= r_p8_sel_right;
            r_p9_ds        <= r_p8_ds;
        end
    end

    // p10: numerator magnitude and sign for the dividers
    logic        r_p10_valid;
    logic [63:0] r_p10_mag [3];
    logic        r_p10_neg [3];
    logic [32:0] r_p10_d;
    t_tail       r_p10_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p10_valid <= 1'b0;
        end else if (w_en) begin
            r_p10_valid <= r_p9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_p10_mag[j] <= r_p9_n[j][63] ? 64'(64'sd0 - r_p9_n[j]) : r_p9_n[j];
                r_p10_neg[j] <= r_p9_n[j][63];
            end
            r_p10_d              <= r_p9_d;
            r_p10_tail.sel_left  <= r_p9_sel_left;
            r_p10_tail.sel_right <= r_p9_sel_right;
            r_p10_tail.res0      <= r_p9_res[0];
            r_p10_tail.res1      <= r_p9_res[1];
            r_p10_tail.res2      <= r_p9_res[2];
            r_p10_tail.ds        <= r_p9_ds;
        end
    end

    // blend division, one divider per flux component
    logic signed [31:0] w_quot [3];

    for (genvar j = 0; j < 3; j++) begin : g_div
        swhf_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mag  (r_p10_mag[j]),
            .i_neg  (r_p10_neg[j]),
            .i_div  (r_p10_d),
            .o_quot (w_quot[j])
        );
    end

    // side data delay matching the dividers
    logic  r_tl_valid [DLAT];
    t_tail r_tl       [DLAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLAT; k++) begin
                r_tl_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_tl_valid[0] <= r_p10_valid;
            for (int k = 1; k < DLAT; k++) begin
                r_tl_valid[k] <= r_tl_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tl[0] <= r_p10_tail;
            for (int k = 1; k < DLAT; k++) begin
                r_tl[k] <= r_tl[k-1];
            end
        end
    end

    // output register: branch select and source difference
    t_tail              w_tl;
    logic               w_blend;
    logic signed [31:0] w_res0, w_res1, w_res2;
    logic signed [31:0] r_out_mass, r_out_normal, r_out_tangent;

    assign w_tl    = r_tl[DLAT-1];
    assign w_blend = !w_tl.sel_left && !w_tl.sel_right;
    assign w_res0  = w_blend ? w_quot[0] : w_tl.res0;
    assign w_res1  = w_blend ? w_quot[1] : w_tl.res1;
    assign w_res2  = w_blend ? w_quot[2] : w_tl.res2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_tl_valid[DLAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_mass    <= swhf_pkg::sat32(66'(w_res0) + 66'(w_tl.ds));
            r_out_normal  <= w_res1;
            r_out_tangent <= w_res2;
        end
    end

    assign o_flux.valid        = r_out_valid;
    assign o_flux.flux_mass    = r_out_mass;
    assign o_flux.flux_normal  = r_out_normal;
    assign o_flux.flux_tangent = r_out_tangent;

endmodule
